// File: hw/rtl/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/acfb_pkg.sv
// shared types, constants and band decode for the crossing counter and bar meter
`timescale 1ns / 1ps
`default_nettype none

package acfb_pkg;

    localparam int SAMPLE_BITS_DEF  = 10;
    localparam int BAR_SEGMENTS_DEF = 8;

    localparam int THR_W       = 9;
    localparam int WIN_W       = 8;
    localparam int BASE_W      = 9;
    localparam int STEP_W      = 6;
    localparam int COUNT_W     = 8;
    localparam int BAND_W      = 8;
    localparam int BAR_W       = 8;
    localparam int EDGE_W      = 10;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    localparam logic [THR_W-1:0]   THR_RESET    = 9'd265;
    localparam logic [WIN_W-1:0]   WIN_RESET    = 8'd80;
    localparam logic [BASE_W-1:0]  BASE_RESET   = 9'd265;
    localparam logic [STEP_W-1:0]  STEP_RESET   = 6'd15;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hff;
    localparam logic [COUNT_W-1:0] BAND_LIMIT   = 8'd35;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CROSS_THRESHOLD = 8'd0,
        REG_WINDOW_TICKS    = 8'd1,
        REG_BAR_BASE        = 8'd2,
        REG_BAR_STEP        = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0]  cross_threshold;
        logic [WIN_W-1:0]  window_ticks;
        logic [BASE_W-1:0] bar_base;
        logic [STEP_W-1:0] bar_step;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic [COUNT_W-1:0] count;
    } win_t;

    function automatic logic [BAND_W-1:0] band_code(input logic [COUNT_W-1:0] n);
        logic [BAND_W-1:0] code;
        case (n) inside
            [8'd1:8'd4]:   code = 8'h01;
            [8'd5:8'd6]:   code = 8'h02;
            [8'd7:8'd10]:  code = 8'h04;
            [8'd11:8'd16]: code = 8'h08;
            [8'd17:8'd20]: code = 8'h10;
            [8'd21:8'd24]: code = 8'h20;
            [8'd25:8'd29]: code = 8'h40;
            [8'd30:8'd34]: code = 8'h80;
            default:       code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acfb_intf.sv
// handshake interfaces for samples, results and register writes
`timescale 1ns / 1ps
`default_nettype none

interface acfb_sample_if #(
    parameter int SAMPLE_BITS = acfb_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface acfb_result_if;
    logic                           valid;
    logic                           ready;
    logic [acfb_pkg::COUNT_W-1:0]   crossing_count;
    logic [acfb_pkg::BAND_W-1:0]    band_onehot;
    logic [acfb_pkg::BAR_W-1:0]     level_bar;

    modport source (output valid, output crossing_count, output band_onehot,
                    output level_bar, input ready);
    modport sink   (input valid, input crossing_count, input band_onehot,
                    input level_bar, output ready);
endinterface

interface acfb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [acfb_pkg::CFG_INDEX_W-1:0] index;
    logic [acfb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/acfb_cfg_regs.sv
// configuration register file with write channel
`timescale 1ns / 1ps
`default_nettype none

module acfb_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    acfb_cfg_if.sink       cfg_ch,
    output acfb_pkg::cfg_t cfg
);

    acfb_pkg::cfg_t cfg_reg;
    acfb_pkg::cfg_t cfg_next;
    logic           wr;

    assign cfg_ch.ready = 1'b1;
    assign wr           = cfg_ch.valid && cfg_ch.ready;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_ch.index)
                acfb_pkg::REG_CROSS_THRESHOLD:
                    cfg_next.cross_threshold = cfg_ch.data[acfb_pkg::THR_W-1:0];
                acfb_pkg::REG_WINDOW_TICKS:
                    cfg_next.window_ticks = cfg_ch.data[acfb_pkg::WIN_W-1:0];
                acfb_pkg::REG_BAR_BASE:
                    cfg_next.bar_base = cfg_ch.data[acfb_pkg::BASE_W-1:0];
                acfb_pkg::REG_BAR_STEP:
                    cfg_next.bar_step = cfg_ch.data[acfb_pkg::STEP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cross_threshold <= acfb_pkg::THR_RESET;
            cfg_reg.window_ticks    <= acfb_pkg::WIN_RESET;
            cfg_reg.bar_base        <= acfb_pkg::BASE_RESET;
            cfg_reg.bar_step        <= acfb_pkg::STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/acfb_window.sv
// crossing detector, crossing counter and window tick counter
`timescale 1ns / 1ps
`default_nettype none

module acfb_window #(
    parameter int SAMPLE_BITS = acfb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [SAMPLE_BITS-2:0] half,
    input  acfb_pkg::cfg_t         cfg,
    output acfb_pkg::win_t         win,
    output logic [acfb_pkg::WIN_W-1:0] tick
);

    localparam int HALF_W = SAMPLE_BITS - 1;
    localparam int CMP_W  = (HALF_W > acfb_pkg::THR_W) ? HALF_W : acfb_pkg::THR_W;

    logic                         above_reg;
    logic                         above_next;
    logic [acfb_pkg::COUNT_W-1:0] count_reg;
    logic [acfb_pkg::COUNT_W-1:0] count_next;
    logic [acfb_pkg::WIN_W-1:0]   tick_reg;
    logic [acfb_pkg::WIN_W-1:0]   tick_next;

    logic                         is_high;
    logic                         bump;
    logic [acfb_pkg::COUNT_W-1:0] count_upd;
    logic [acfb_pkg::WIN_W-1:0]   tick_inc;
    logic [acfb_pkg::WIN_W-1:0]   limit;

    assign is_high   = CMP_W'(half) >= CMP_W'(cfg.cross_threshold);
    // count a crossing once per excursion, saturating
    assign bump      = is_high && !above_reg && (count_reg != acfb_pkg::COUNT_MAX);
    assign count_upd = count_reg + acfb_pkg::COUNT_W'(bump);

    // a zero window behaves as one tick
    assign limit     = (cfg.window_ticks == '0) ? acfb_pkg::WIN_W'(1) : cfg.window_ticks;
    assign tick_inc  = tick_reg + acfb_pkg::WIN_W'(1);

    assign win.emit  = tick_inc >= limit;
    assign win.count = count_upd;
    assign tick      = tick_reg;

    always_comb
    begin
        above_next = above_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        if (fire)
        begin
            above_next = is_high;
            count_next = win.emit ? '0 : count_upd;
            tick_next  = win.emit ? '0 : tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            count_reg <= '0;
            tick_reg  <= '0;
        end
        else
        begin
            above_reg <= above_next;
            count_reg <= count_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/acfb_meter.sv
// band decode and thermometer level bar
`timescale 1ns / 1ps
`default_nettype none

module acfb_meter #(
    parameter int SAMPLE_BITS  = acfb_pkg::SAMPLE_BITS_DEF,
    parameter int BAR_SEGMENTS = acfb_pkg::BAR_SEGMENTS_DEF
) (
    input  logic [acfb_pkg::COUNT_W-1:0] count,
    input  logic [SAMPLE_BITS-2:0]       half,
    input  acfb_pkg::cfg_t               cfg,
    output logic [acfb_pkg::BAND_W-1:0]  band,
    output logic [acfb_pkg::BAR_W-1:0]   bar
);

    localparam int HALF_W = SAMPLE_BITS - 1;
    localparam int CMP_W  = (HALF_W > acfb_pkg::EDGE_W) ? HALF_W : acfb_pkg::EDGE_W;
    localparam int NSEG   = (BAR_SEGMENTS < acfb_pkg::BAR_W) ? BAR_SEGMENTS : acfb_pkg::BAR_W;

    assign band = acfb_pkg::band_code(count);

    // one comparator per segment, segment edges rise by bar_step
    for (genvar i = 0; i < acfb_pkg::BAR_W; i++)
    begin : g_seg
        if (i < NSEG)
        begin : g_on
            logic [CMP_W-1:0] seg_edge;
            assign seg_edge = CMP_W'(cfg.bar_base) + CMP_W'(cfg.bar_step) * CMP_W'(i);
            assign bar[i]   = CMP_W'(half) >= seg_edge;
        end
        else
        begin : g_off
            assign bar[i] = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/audio_crossing_freq_and_level_bar_core.sv
// a sample accepted into the input register updates the counters from there and, at the
// end of a window, loads the result register when it is processed
// throughput: one sample per cycle; only a full result register left untaken stalls
// a window-closing sample, held in the input register
// reset: counters, above flag and valids clear, cfg registers return to their defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module audio_crossing_freq_and_level_bar_core #(
    parameter int SAMPLE_BITS  = acfb_pkg::SAMPLE_BITS_DEF,
    parameter int BAR_SEGMENTS = acfb_pkg::BAR_SEGMENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    acfb_sample_if.sink   sample_ch,
    acfb_result_if.source result_ch,
    acfb_cfg_if.sink      cfg_ch
);

    localparam int HALF_W = SAMPLE_BITS - 1;

    acfb_pkg::cfg_t cfg;
    acfb_pkg::win_t win;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [SAMPLE_BITS-1:0]       sample_reg;
    logic [HALF_W-1:0]            half;
    logic                         accept;
    logic                         out_free;
    logic                         proc_fire;
    logic                         load;
    logic [acfb_pkg::WIN_W-1:0]   tick;
    logic [acfb_pkg::BAND_W-1:0]  band;
    logic [acfb_pkg::BAR_W-1:0]   bar;

    logic                         result_valid_reg;
    logic                         result_valid_next;
    logic [acfb_pkg::COUNT_W-1:0] count_reg;
    logic [acfb_pkg::BAND_W-1:0]  band_reg;
    logic [acfb_pkg::BAR_W-1:0]   bar_reg;

    acfb_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    assign half = sample_reg[SAMPLE_BITS-1:1];

    acfb_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc_fire),
        .half  (half),
        .cfg   (cfg),
        .win   (win),
        .tick  (tick)
    );

    acfb_meter #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .BAR_SEGMENTS (BAR_SEGMENTS)
    ) u_meter (
        .count (win.count),
        .half  (half),
        .cfg   (cfg),
        .band  (band),
        .bar   (bar)
    );

    // a sample that closes a window waits only for room in the result register
    assign out_free        = !result_valid_reg || result_ch.ready;
    assign proc_fire       = s1_valid_reg && (!win.emit || out_free);
    assign load            = proc_fire && win.emit;
    assign sample_ch.ready = !s1_valid_reg || proc_fire;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            s1_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_ch.sample[SAMPLE_BITS-1:0];
        end
        if (load)
        begin
            count_reg <= win.count;
            band_reg  <= band;
            bar_reg   <= bar;
        end
    end

    assign result_ch.valid          = result_valid_reg;
    assign result_ch.crossing_count = count_reg;
    assign result_ch.band_onehot    = band_reg;
    assign result_ch.level_bar      = bar_reg;

    `ASSERT_IMPLY(a_band_onehot, clk, rst_n, result_valid_reg, $onehot0(band_reg))
    `ASSERT_IMPLY(a_band_range, clk, rst_n, result_valid_reg,
        (band_reg == '0) == ((count_reg == '0) || (count_reg >= acfb_pkg::BAND_LIMIT)))
    `ASSERT_IMPLY(a_bar_thermo, clk, rst_n, result_valid_reg,
        (bar_reg & (bar_reg + acfb_pkg::BAR_W'(1))) == '0)
    `ASSERT_NEXT(a_window_clear, clk, rst_n, load, tick == '0)

endmodule

`default_nettype wire
